@@ src/frqc_pkg.sv @@
// Shared types and constants for the freed-region quarantine checker.
// Depends on nothing. Used by frqc_cell and freed_region_quarantine_checker.
package frqc_pkg;

  localparam int QD    = 64;          // number of table entries (cells)
  localparam int QD_W  = $clog2(QD);  // slot index width
  localparam int ADR_W = 64;
  localparam int SZ_W  = 32;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_DEALLOC = 2'd1,
    OP_ACCESS  = 2'd2
  } op_t;

  // Request token walking the row of cells
  typedef struct packed {
    logic              active;
    op_t               op;
    logic [ADR_W-1:0]  addr;
    logic [SZ_W-1:0]   size;
    logic              wr;
    logic              match;       // a valid entry holds this base
    logic              free_found;  // an invalid slot was seen
    logic [QD_W-1:0]   free_idx;    // lowest invalid slot
    logic              hit;
    logic [ADR_W-1:0]  fbase;
    logic [SZ_W-1:0]   fbytes;
  } tok_t;

  // Insert of a new base into one slot, broadcast to all cells
  typedef struct packed {
    logic              we;
    logic [QD_W-1:0]   idx;
    logic [ADR_W-1:0]  base;
    logic [SZ_W-1:0]   bytes;
  } commit_t;

endpackage

@@ src/frqc_cell.sv @@
// One table slot of the quarantine checker plus one stage of the token row.
// Depends on frqc_pkg (tok_t, commit_t, op_t).
module frqc_cell
  import frqc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,       // row advances this cycle
  input  logic [QD_W-1:0] cell_idx,  // this slot's number
  input  tok_t            tok_in,
  input  commit_t         cmt,
  output tok_t            tok_out
);

  logic             valid_r, valid_nxt;
  logic [ADR_W-1:0] base_r, base_nxt;
  logic [SZ_W-1:0]  bytes_r, bytes_nxt;
  tok_t             tok_r, tok_nxt;

  // Work the passing request against this slot
  always_comb begin
    logic             match_here;
    logic [ADR_W-1:0] diff;
    logic             in_range;
    match_here = valid_r && (base_r == tok_in.addr);
    diff       = tok_in.addr - base_r;
    in_range   = valid_r && (tok_in.addr >= base_r) &&
                 (diff < {{(ADR_W-SZ_W){1'b0}}, bytes_r});
    valid_nxt  = valid_r;
    base_nxt   = base_r;
    bytes_nxt  = bytes_r;
    tok_nxt    = tok_in;
    if (tok_in.active) begin
      unique case (tok_in.op)
        OP_ALLOC: begin
          if (match_here) valid_nxt = 1'b0;
        end
        OP_DEALLOC: begin
          if (match_here) begin
            tok_nxt.match = 1'b1;
            bytes_nxt     = tok_in.size;
          end
          if (!valid_r && !tok_in.free_found) begin
            tok_nxt.free_found = 1'b1;
            tok_nxt.free_idx   = cell_idx;
          end
        end
        OP_ACCESS: begin
          if (in_range && (!tok_in.hit || base_r < tok_in.fbase)) begin
            tok_nxt.hit    = 1'b1;
            tok_nxt.fbase  = base_r;
            tok_nxt.fbytes = bytes_r;
          end
        end
        default: ;
      endcase
    end
    // Insert of a new base lands in the chosen slot
    if (cmt.we && (cmt.idx == cell_idx)) begin
      valid_nxt = 1'b1;
      base_nxt  = cmt.base;
      bytes_nxt = cmt.bytes;
    end
  end

  // Slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base_r  <= base_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  // Hand the request to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ src/freed_region_quarantine_checker.sv @@
// Top level of the freed-region quarantine checker: request intake, cell row,
// result register. Depends on frqc_pkg and frqc_cell.
//
// The table of freed regions lives in a row of QD cells (64), one entry per
// cell. An accepted request walks the row one cell per cycle unless the row
// is held, each cell matching, updating or range-checking against its own
// entry, and the result is registered when the request leaves the last cell;
// a deallocate of a new base is written into the lowest free slot at that
// moment. One request is in the row at a time: the next request can be
// accepted once the result is registered, even while that result still
// waits on out_tready. A waiting result stalls the row only once the next
// request reaches the last cell. All entries are invalid after reset; no
// clearing pass is needed.
module freed_region_quarantine_checker
  import frqc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // address[63:0], block_size[95:64]
  input  logic [2:0]   in_tuser,   // op[1:0], access_wr[2]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // freed_base[63:0], freed_bytes[95:64]
  output logic [2:0]   out_tuser   // hit[0], write_access[1], table_full[2]
);

  tok_t    head;
  tok_t    tok [QD];
  tok_t    tail;
  commit_t cmt;
  logic    adv, take, accept;
  logic    busy_r, busy_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  assign tail      = tok[QD-1];
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  // Hold the row while the finished result cannot leave
  assign adv       = !(tail.active && out_valid_r && !out_tready);
  assign take      = tail.active && adv;

  // Build the request entering the first cell
  always_comb begin
    head            = '0;
    head.active     = accept;
    head.op         = op_t'(in_tuser[1:0]);
    head.addr       = in_tdata[63:0];
    head.size       = in_tdata[95:64];
    head.wr         = in_tuser[2];
  end

  // Row of cells
  for (genvar i = 0; i < QD; i++) begin : g_cell
    if (i == 0) begin : g_first
      frqc_cell u_cell (
        .clk(clk), .rst_n(rst_n), .adv(adv), .cell_idx(QD_W'(i)),
        .tok_in(head), .cmt(cmt), .tok_out(tok[i])
      );
    end else begin : g_next
      frqc_cell u_cell (
        .clk(clk), .rst_n(rst_n), .adv(adv), .cell_idx(QD_W'(i)),
        .tok_in(tok[i-1]), .cmt(cmt), .tok_out(tok[i])
      );
    end
  end

  // Insert a new base when the deallocate leaves the row
  always_comb begin
    cmt       = '0;
    cmt.we    = take && (tail.op == OP_DEALLOC) && !tail.match && tail.free_found;
    cmt.idx   = tail.free_idx;
    cmt.base  = tail.addr;
    cmt.bytes = tail.size;
  end

  // Result and busy tracking
  always_comb begin
    logic is_hit;
    is_hit        = (tail.op == OP_ACCESS) && tail.hit;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (accept) busy_nxt = 1'b1;
    if (take) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = is_hit ? {tail.fbytes, tail.fbase} : '0;
      out_user_nxt  = {(tail.op == OP_DEALLOC) && !tail.match && !tail.free_found,
                       is_hit && tail.wr, is_hit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A request is taken only with the row empty
  a_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !tail.active)
    else $error("request accepted while the row is busy");

  // An accepted request blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted during a walk");

  // A result is never both a hit and a dropped insert
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[2]))
    else $error("hit and table_full both set");

  // Inserts happen only as a result is registered
  a_commit_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmt.we |=> out_tvalid)
    else $error("insert without a result");

endmodule
